FILE: src/lltp_pkg.sv
// ----------------------------------------------------------------------------
// LLDP TLV parser package
// Shared types, flag bits, tag codes and sizing constants.
// ----------------------------------------------------------------------------
package lltp_pkg;

    localparam int TTL_SLOTS = 8;
    localparam int TTL_IDX_W = (TTL_SLOTS > 1) ? $clog2(TTL_SLOTS) : 1;
    localparam int TTL_CNT_W = $clog2(TTL_SLOTS + 1);

    // configuration register indexes
    localparam logic [1:0] REG_MAX_STR  = 2'd0;
    localparam logic [1:0] REG_OPT_EN   = 2'd1;
    localparam logic [1:0] REG_TTL_AGG  = 2'd2;

    // status flag bits
    localparam logic [8:0] F_OPT   = 9'h001;
    localparam logic [8:0] F_TRUNC = 9'h002;
    localparam logic [8:0] F_SNAP  = 9'h004;
    localparam logic [8:0] F_SHORT = 9'h008;
    localparam logic [8:0] F_RSVD  = 9'h010;
    localparam logic [8:0] F_TTL   = 9'h020;
    localparam logic [8:0] F_ORG   = 9'h040;
    localparam logic [8:0] F_MAND  = 9'h080;

    // how many bytes of a loaded field are kept
    localparam logic [1:0] KEEP_NONE = 2'd0;
    localparam logic [1:0] KEEP_ALL  = 2'd1;
    localparam logic [1:0] KEEP_STR  = 2'd2;
    localparam logic [1:0] KEEP_HEX  = 2'd3;

    // output field tags
    localparam logic [3:0] TAG_NONE    = 4'd0;
    localparam logic [3:0] TAG_CHASSIS = 4'd1;
    localparam logic [3:0] TAG_PORT    = 4'd2;
    localparam logic [3:0] TAG_PDESC   = 4'd3;
    localparam logic [3:0] TAG_SYSNAME = 4'd4;
    localparam logic [3:0] TAG_SYSDESC = 4'd5;
    localparam logic [3:0] TAG_MGMT    = 4'd6;
    localparam logic [3:0] TAG_TTL     = 4'd7;
    localparam logic [3:0] TAG_CAPS    = 4'd8;

    typedef struct packed {
        logic       clear_flow;
        logic       parser_rst;
        logic       ld_word;
        logic       ld_hdr;
        logic       ld_sub;
        logic       ld_aoid;
        logic       cnt_load;
        logic [8:0] cnt_val;
        logic [1:0] keep_mode;
        logic       dec_rem;
        logic       dec_kept;
        logic       caps_step;
        logic       ttl_store;
        logic       mand_chk;
        logic [8:0] flag_set;
        logic [3:0] tag;
        logic       valid;
        logic       done;
    } cmd_t;

    typedef struct packed {
        logic [15:0] word;
        logic [6:0]  tlv_type;
        logic [8:0]  tlv_length;
        logic [7:0]  aoid_len;
        logic        rem_le1;
        logic        kept_nz;
        logic        opt_en;
    } stat_t;

    typedef struct packed {
        logic [3:0]  field_tag;
        logic [7:0]  field_subtype;
        logic [7:0]  field_byte;
        logic        byte_valid;
        logic        frame_done;
        logic [8:0]  status_flags;
        logic [15:0] supported_caps;
        logic [15:0] caps_enabled;
        logic [3:0]  ttl_count;
    } res_t;

    function automatic logic [3:0] tag_of_type(input logic [6:0] t);
        logic [3:0] r;
        case (t)
            7'd1:    r = TAG_CHASSIS;
            7'd2:    r = TAG_PORT;
            7'd3:    r = TAG_TTL;
            7'd4:    r = TAG_PDESC;
            7'd5:    r = TAG_SYSNAME;
            7'd6:    r = TAG_SYSDESC;
            7'd7:    r = TAG_CAPS;
            7'd8:    r = TAG_MGMT;
            default: r = TAG_NONE;
        endcase
        return r;
    endfunction

endpackage

FILE: src/lltp_ctrl.sv
// ----------------------------------------------------------------------------
// LLDP TLV parser controller
// Parse phase state machine; issues load/count commands to the datapath.
// ----------------------------------------------------------------------------
module lltp_ctrl
    import lltp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       command,
    input  logic [7:0] data_byte,
    input  logic       frame_last,
    input  stat_t      stat,
    output cmd_t       cmd
);

    localparam logic [4:0] PH_HDR0   = 5'd0;
    localparam logic [4:0] PH_HDR1   = 5'd1;
    localparam logic [4:0] PH_SUB    = 5'd2;
    localparam logic [4:0] PH_FAM    = 5'd3;
    localparam logic [4:0] PH_FIELD  = 5'd4;
    localparam logic [4:0] PH_SKIP   = 5'd5;
    localparam logic [4:0] PH_TTL0   = 5'd6;
    localparam logic [4:0] PH_TTL1   = 5'd7;
    localparam logic [4:0] PH_CAPS   = 5'd8;
    localparam logic [4:0] PH_MLEN   = 5'd9;
    localparam logic [4:0] PH_MFAM   = 5'd10;
    localparam logic [4:0] PH_MIFT   = 5'd11;
    localparam logic [4:0] PH_MIFN   = 5'd12;
    localparam logic [4:0] PH_MOIDL  = 5'd13;
    localparam logic [4:0] PH_MOID   = 5'd14;
    localparam logic [4:0] PH_OUI    = 5'd15;
    localparam logic [4:0] PH_ORGSUB = 5'd16;

    logic [4:0] phase_reg, phase_next;
    logic       halted_reg, halted_next;

    logic [6:0] hdr_type;
    logic [8:0] hdr_len;
    logic [2:0] kind;
    logic [8:0] aoid_m1;

    assign hdr_type = stat.word[7:1];
    assign hdr_len  = {stat.word[0], data_byte};
    assign aoid_m1  = {1'b0, stat.aoid_len} - 9'd1;

    // ID subtype class: 1 string, 2 hex, 4 address, 5 skipped, 0 reserved
    always_comb
    begin
        kind = 3'd0;
        if (stat.tlv_type == 7'd1)
        begin
            case (data_byte)
                8'd1, 8'd2, 8'd4, 8'd6, 8'd7: kind = 3'd1;
                8'd3:    kind = 3'd2;
                8'd5:    kind = 3'd4;
                default: kind = 3'd0;
            endcase
        end
        else
        begin
            case (data_byte)
                8'd1, 8'd3, 8'd5, 8'd7: kind = 3'd1;
                8'd2:    kind = 3'd2;
                8'd4:    kind = 3'd4;
                8'd6:    kind = 3'd5;
                default: kind = 3'd0;
            endcase
        end
    end

    always_comb
    begin
        cmd         = '0;
        phase_next  = phase_reg;
        halted_next = halted_reg;
        if (step)
        begin
            if (command)
            begin
                cmd.clear_flow = 1'b1;
                phase_next     = PH_HDR0;
                halted_next    = 1'b0;
            end
            else
            begin
                if (!halted_reg && !(phase_reg == PH_HDR0 && frame_last))
                begin
                    if (phase_reg == PH_HDR0 || phase_reg == PH_HDR1)
                        cmd.tag = TAG_NONE;
                    else if (phase_reg == PH_SKIP && stat.tlv_type >= 7'd4)
                        cmd.tag = TAG_NONE;
                    else
                        cmd.tag = tag_of_type(stat.tlv_type);

                    case (phase_reg)
                        PH_HDR0:
                        begin
                            cmd.ld_word = 1'b1;
                            phase_next  = PH_HDR1;
                        end
                        PH_HDR1:
                        begin
                            cmd.ld_hdr = 1'b1;
                            if (hdr_type == 7'd0)
                            begin
                                cmd.mand_chk = 1'b1;
                                halted_next  = 1'b1;
                            end
                            else if (hdr_type == 7'd1 || hdr_type == 7'd2)
                                phase_next = PH_SUB;
                            else if (hdr_type == 7'd3)
                                phase_next = PH_TTL0;
                            else if ((hdr_type > 7'd8 && hdr_type < 7'd127)
                                     || !stat.opt_en)
                            begin
                                if (hdr_type > 7'd8 && hdr_type < 7'd127)
                                    cmd.flag_set = F_RSVD;
                                cmd.cnt_load = 1'b1;
                                cmd.cnt_val  = hdr_len;
                                phase_next   = (hdr_len == 9'd0) ? PH_HDR0 : PH_SKIP;
                            end
                            else if (hdr_type <= 7'd6)
                            begin
                                if (hdr_len == 9'd0)
                                begin
                                    cmd.flag_set = F_SHORT;
                                    halted_next  = 1'b1;
                                end
                                else
                                begin
                                    cmd.cnt_load  = 1'b1;
                                    cmd.cnt_val   = hdr_len;
                                    cmd.keep_mode = KEEP_STR;
                                    phase_next    = PH_FIELD;
                                end
                            end
                            else if (hdr_type == 7'd7)
                            begin
                                cmd.cnt_load = 1'b1;
                                cmd.cnt_val  = 9'd4;
                                phase_next   = PH_CAPS;
                            end
                            else if (hdr_type == 7'd8)
                                phase_next = PH_MLEN;
                            else
                            begin
                                cmd.flag_set = F_ORG;
                                cmd.cnt_load = 1'b1;
                                cmd.cnt_val  = 9'd3;
                                phase_next   = PH_OUI;
                            end
                        end
                        PH_SUB:
                        begin
                            cmd.ld_sub = 1'b1;
                            if (kind == 3'd4)
                                phase_next = PH_FAM;
                            else if (kind == 3'd0)
                            begin
                                cmd.flag_set = F_RSVD;
                                if (stat.tlv_length == 9'd0)
                                begin
                                    cmd.flag_set = F_RSVD | F_SHORT;
                                    halted_next  = 1'b1;
                                end
                                else
                                begin
                                    cmd.cnt_load = 1'b1;
                                    cmd.cnt_val  = stat.tlv_length - 9'd1;
                                    phase_next   = (stat.tlv_length == 9'd1) ?
                                                   PH_HDR0 : PH_SKIP;
                                end
                            end
                            else if (stat.tlv_length < 9'd2)
                            begin
                                cmd.flag_set = F_SHORT;
                                halted_next  = 1'b1;
                            end
                            else
                            begin
                                cmd.cnt_load = 1'b1;
                                cmd.cnt_val  = stat.tlv_length - 9'd1;
                                if (kind == 3'd5)
                                    phase_next = PH_SKIP;
                                else
                                begin
                                    cmd.keep_mode = (kind == 3'd2) ? KEEP_HEX : KEEP_STR;
                                    phase_next    = PH_FIELD;
                                end
                            end
                        end
                        PH_FAM:
                        begin
                            cmd.ld_sub = 1'b1;
                            if (data_byte == 8'd1 || data_byte == 8'd2)
                            begin
                                cmd.cnt_load  = 1'b1;
                                cmd.cnt_val   = (data_byte == 8'd1) ? 9'd4 : 9'd16;
                                cmd.keep_mode = KEEP_ALL;
                                phase_next    = PH_FIELD;
                            end
                            else if (stat.tlv_length < 9'd3)
                            begin
                                cmd.flag_set = F_SHORT;
                                halted_next  = 1'b1;
                            end
                            else
                            begin
                                cmd.cnt_load  = 1'b1;
                                cmd.cnt_val   = stat.tlv_length - 9'd2;
                                cmd.keep_mode = KEEP_HEX;
                                phase_next    = PH_FIELD;
                            end
                        end
                        PH_FIELD:
                        begin
                            cmd.valid    = stat.kept_nz;
                            cmd.dec_kept = 1'b1;
                            cmd.dec_rem  = 1'b1;
                            if (stat.rem_le1)
                                phase_next = (stat.tlv_type == 7'd8) ? PH_MIFT : PH_HDR0;
                        end
                        PH_SKIP, PH_MOID:
                        begin
                            cmd.dec_rem = 1'b1;
                            if (stat.rem_le1)
                                phase_next = PH_HDR0;
                        end
                        PH_TTL0:
                        begin
                            cmd.ld_word = 1'b1;
                            cmd.valid   = 1'b1;
                            phase_next  = PH_TTL1;
                        end
                        PH_TTL1:
                        begin
                            cmd.ttl_store = 1'b1;
                            cmd.valid     = 1'b1;
                            phase_next    = PH_HDR0;
                        end
                        PH_CAPS:
                        begin
                            cmd.caps_step = 1'b1;
                            cmd.valid     = 1'b1;
                            if (stat.rem_le1)
                                phase_next = PH_HDR0;
                        end
                        PH_MLEN:
                        begin
                            cmd.ld_aoid = 1'b1;
                            phase_next  = PH_MFAM;
                        end
                        PH_MFAM:
                        begin
                            cmd.ld_sub = 1'b1;
                            if (data_byte == 8'd1 || data_byte == 8'd2)
                            begin
                                cmd.cnt_load  = 1'b1;
                                cmd.cnt_val   = (data_byte == 8'd1) ? 9'd4 : 9'd16;
                                cmd.keep_mode = KEEP_ALL;
                                phase_next    = PH_FIELD;
                            end
                            else if (stat.aoid_len < 8'd2)
                            begin
                                cmd.flag_set = F_SHORT;
                                halted_next  = 1'b1;
                            end
                            else
                            begin
                                cmd.cnt_load  = 1'b1;
                                cmd.cnt_val   = aoid_m1;
                                cmd.keep_mode = KEEP_HEX;
                                phase_next    = PH_FIELD;
                            end
                        end
                        PH_MIFT:
                        begin
                            cmd.cnt_load = 1'b1;
                            cmd.cnt_val  = 9'd4;
                            phase_next   = PH_MIFN;
                        end
                        PH_MIFN:
                        begin
                            cmd.dec_rem = 1'b1;
                            if (stat.rem_le1)
                                phase_next = PH_MOIDL;
                        end
                        PH_MOIDL:
                        begin
                            cmd.ld_aoid = 1'b1;
                            if (data_byte > 8'd1)
                            begin
                                cmd.cnt_load = 1'b1;
                                cmd.cnt_val  = {1'b0, data_byte};
                                phase_next   = PH_MOID;
                            end
                            else
                                phase_next = PH_HDR0;
                        end
                        PH_OUI:
                        begin
                            cmd.dec_rem = 1'b1;
                            if (stat.rem_le1)
                                phase_next = PH_ORGSUB;
                        end
                        PH_ORGSUB:
                        begin
                            cmd.ld_sub = 1'b1;
                            if (stat.tlv_length < 9'd4)
                            begin
                                cmd.flag_set = F_SHORT;
                                halted_next  = 1'b1;
                            end
                            else
                            begin
                                cmd.cnt_load = 1'b1;
                                cmd.cnt_val  = stat.tlv_length - 9'd4;
                                phase_next   = (stat.tlv_length == 9'd4) ? PH_HDR0 : PH_SKIP;
                            end
                        end
                        default:
                            phase_next = PH_HDR0;
                    endcase
                end

                if (frame_last)
                begin
                    cmd.done = 1'b1;
                    if (!halted_next)
                    begin
                        if (phase_next == PH_HDR0)
                            cmd.mand_chk = 1'b1;
                        else
                            cmd.flag_set = cmd.flag_set | F_SNAP;
                    end
                    cmd.parser_rst = 1'b1;
                    phase_next     = PH_HDR0;
                    halted_next    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: src/lltp_dp.sv
// ----------------------------------------------------------------------------
// LLDP TLV parser datapath
// TLV header, counters, sticky flags, capability words and TTL list.
// ----------------------------------------------------------------------------
module lltp_dp
    import lltp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [8:0] cfg_wdata,
    input  logic [7:0] data_byte,
    input  cmd_t       cmd,
    output stat_t      stat,
    output res_t       res
);

    logic [8:0]  max_str_reg;
    logic        opt_en_reg;
    logic        ttl_agg_reg;

    logic [15:0] word_reg, word_next;
    logic [6:0]  type_reg, type_next;
    logic [8:0]  len_reg, len_next;
    logic [8:0]  rem_reg, rem_next;
    logic [8:0]  kept_reg, kept_next;
    logic [7:0]  sub_reg, sub_next;
    logic [7:0]  aoid_reg, aoid_next;
    logic [3:0]  mask_reg, mask_next;
    logic [8:0]  flags_reg, flags_next;
    logic [15:0] sup_reg, sup_next;
    logic [15:0] en_reg, en_next;
    logic [TTL_CNT_W-1:0] stored_reg, stored_next;

    logic [15:0] ttl_store [TTL_SLOTS];
    logic [15:0] ttl_val;
    logic        ttl_hit;
    logic        ttl_wr;
    logic [8:0]  limit;
    logic [8:0]  rem_dec;
    logic [15:0] caps_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_str_reg <= 9'd255;
            opt_en_reg  <= 1'b1;
            ttl_agg_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_MAX_STR: max_str_reg <= cfg_wdata;
                REG_OPT_EN:  opt_en_reg  <= cfg_wdata[0];
                REG_TTL_AGG: ttl_agg_reg <= cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    assign ttl_val   = {word_reg[7:0], data_byte};
    assign caps_word = {word_reg[7:0], data_byte};
    assign rem_dec   = (rem_reg != 9'd0) ? rem_reg - 9'd1 : 9'd0;
    assign limit     = (cmd.keep_mode == KEEP_HEX) ? {1'b0, max_str_reg[8:1]} : max_str_reg;

    // duplicate search over the filled slots, all in parallel
    always_comb
    begin
        ttl_hit = 1'b0;
        for (int i = 0; i < TTL_SLOTS; i++)
            if (TTL_CNT_W'(i) < stored_reg && ttl_store[i] == ttl_val)
                ttl_hit = 1'b1;
    end

    always_comb
    begin
        word_next   = word_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        kept_next   = kept_reg;
        sub_next    = sub_reg;
        aoid_next   = aoid_reg;
        mask_next   = mask_reg;
        flags_next  = flags_reg | cmd.flag_set;
        sup_next    = sup_reg;
        en_next     = en_reg;
        stored_next = stored_reg;
        ttl_wr      = 1'b0;

        if (cmd.ld_word)
            word_next = {8'h00, data_byte};
        if (cmd.ld_hdr)
        begin
            type_next = word_reg[7:1];
            len_next  = {word_reg[0], data_byte};
            sub_next  = 8'h00;
            if (word_reg[7:1] < 7'd4)
                mask_next = mask_reg | (4'b0001 << word_reg[2:1]);
            else if (word_reg[7:1] <= 7'd8)
                flags_next = flags_next | F_OPT;
        end
        if (cmd.ld_sub)
            sub_next = data_byte;
        if (cmd.ld_aoid)
            aoid_next = data_byte;
        if (cmd.cnt_load)
        begin
            rem_next = cmd.cnt_val;
            case (cmd.keep_mode)
                KEEP_NONE: kept_next = 9'd0;
                KEEP_ALL:  kept_next = cmd.cnt_val;
                default:
                begin
                    if (cmd.cnt_val > limit)
                    begin
                        kept_next  = limit;
                        flags_next = flags_next | F_TRUNC;
                    end
                    else
                        kept_next = cmd.cnt_val;
                end
            endcase
        end
        if (cmd.dec_rem)
            rem_next = rem_dec;
        if (cmd.dec_kept && kept_reg != 9'd0)
            kept_next = kept_reg - 9'd1;
        if (cmd.caps_step)
        begin
            word_next = caps_word;
            rem_next  = rem_dec;
            if (rem_dec == 9'd0)
                en_next = en_reg | caps_word;
            else if (rem_dec == 9'd2)
                sup_next = sup_reg | caps_word;
        end
        if (cmd.ttl_store && !(ttl_agg_reg && ttl_hit))
        begin
            if (stored_reg < TTL_CNT_W'(TTL_SLOTS))
            begin
                ttl_wr      = 1'b1;
                stored_next = stored_reg + 1'b1;
            end
            else
                flags_next = flags_next | F_TTL;
        end
        if (cmd.mand_chk && mask_next != 4'hf)
            flags_next = flags_next | F_MAND;

        // result subtype is taken before the end-of-frame reset
        res.field_tag      = cmd.tag;
        res.field_subtype  = (cmd.tag != TAG_NONE) ? sub_next : 8'h00;
        res.field_byte     = cmd.valid ? data_byte : 8'h00;
        res.byte_valid     = cmd.valid;
        res.frame_done     = cmd.done;

        if (cmd.parser_rst || cmd.clear_flow)
        begin
            word_next = '0;
            type_next = '0;
            len_next  = '0;
            rem_next  = '0;
            kept_next = '0;
            sub_next  = '0;
            aoid_next = '0;
            mask_next = '0;
        end
        if (cmd.clear_flow)
        begin
            flags_next  = '0;
            sup_next    = '0;
            en_next     = '0;
            stored_next = '0;
        end

        res.status_flags   = flags_next;
        res.supported_caps = sup_next;
        res.caps_enabled   = en_next;
        res.ttl_count      = 4'(stored_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg   <= '0;
            type_reg   <= '0;
            len_reg    <= '0;
            rem_reg    <= '0;
            kept_reg   <= '0;
            sub_reg    <= '0;
            aoid_reg   <= '0;
            mask_reg   <= '0;
            flags_reg  <= '0;
            sup_reg    <= '0;
            en_reg     <= '0;
            stored_reg <= '0;
        end
        else
        begin
            word_reg   <= word_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            kept_reg   <= kept_next;
            sub_reg    <= sub_next;
            aoid_reg   <= aoid_next;
            mask_reg   <= mask_next;
            flags_reg  <= flags_next;
            sup_reg    <= sup_next;
            en_reg     <= en_next;
            stored_reg <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ttl_wr)
            ttl_store[stored_reg[TTL_IDX_W-1:0]] <= ttl_val;
    end

    assign stat.word       = word_reg;
    assign stat.tlv_type   = type_reg;
    assign stat.tlv_length = len_reg;
    assign stat.aoid_len   = aoid_reg;
    assign stat.rem_le1    = (rem_reg <= 9'd1);
    assign stat.kept_nz    = (kept_reg != 9'd0);
    assign stat.opt_en     = opt_en_reg;

endmodule

FILE: src/lldp_tlv_frame_parser.sv
// ----------------------------------------------------------------------------
// LLDP TLV frame parser
// Byte-stream LLDPDU decoder emitting one tagged result per input beat.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  s_*     | in  | tdata: data_byte; tuser: command; tlast: frame_last
//  m_*     | out | tdata: subtype, byte, flags, caps, ttl count; tuser: tag,
//          |     | byte_valid; tlast: frame_done
//  cfg_*   | in  | write enable, register index, 9-bit data
//
//  One beat in, one beat out. Each byte is decoded in the cycle it is taken
//  and its result sits in the output register the next cycle: one byte per
//  clock while m_tready holds. The parse state and TTL duplicate compare
//  settle in that single cycle. A stalled output blocks input (s_tready low)
//  until the held beat is taken. Reset restores the configuration defaults
//  and an empty flow record; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lldp_tlv_frame_parser
    import lltp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] field_subtype, [15:8] field_byte,
                                   // [24:16] status_flags, [40:25] supported_caps,
                                   // [56:41] caps_enabled, [60:57] ttl_count, pad
    output logic [4:0]  m_tuser,   // [3:0] field_tag, [4] byte_valid
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;
    res_t  res;
    res_t  out_reg;
    logic  out_valid_reg;
    logic  step;

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    lltp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .command    (s_tuser),
        .data_byte  (s_tdata),
        .frame_last (s_tlast),
        .stat       (stat),
        .cmd        (cmd)
    );

    lltp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.frame_done;
    assign m_tuser  = {out_reg.byte_valid, out_reg.field_tag};
    assign m_tdata  = {3'b000, out_reg.ttl_count, out_reg.caps_enabled,
                       out_reg.supported_caps, out_reg.status_flags,
                       out_reg.field_byte, out_reg.field_subtype};

endmodule

FILE: src/lltp_checker.sv
// ----------------------------------------------------------------------------
// LLDP TLV parser port checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module lltp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [4:0]  m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output payload changed while stalled");

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=>
            m_tdata[60:16] == 45'd0 && m_tuser == 5'd0)
        else $error("clear left flow state behind");

    a_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4] |-> m_tuser[3:0] != 4'd0)
        else $error("kept byte without a field tag");

endmodule

bind lldp_tlv_frame_parser lltp_checker u_lltp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LLDP TLV frame parser testbench
// Feeds LLDPDU byte streams (well-formed frames with random content, broken
// and noise frames, flow clears) under random backpressure. A behavioral copy
// of the decoder predicts every output beat, which is then compared in order.
// ----------------------------------------------------------------------------
module tb;
    import lltp_pkg::*;

    typedef enum logic [4:0] {
        P_HDR0, P_HDR1, P_SUB, P_FAM, P_FIELD, P_SKIP, P_TTL0, P_TTL1, P_CAPS,
        P_MLEN, P_MFAM, P_MIFT, P_MIFN, P_MOIDL, P_MOID, P_OUI, P_ORGSUB
    } phase_t;

    typedef struct {
        bit       clear;
        bit [7:0] data;
        bit       last;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [8:0]  cfg_wdata;

    lldp_tlv_frame_parser dut (.*);

    // model configuration
    bit [8:0] str_limit;
    bit       opt_en;
    bit       ttl_dedup;

    // model parser state
    phase_t    phase;
    bit [6:0]  cur_type;
    bit [8:0]  cur_len;
    bit [8:0]  remaining;
    bit [8:0]  kept;
    bit [7:0]  cur_sub;
    bit [7:0]  aoid_len;
    bit [15:0] word;
    bit [3:0]  mand_seen;
    bit        halted;
    bit [8:0]  flags;
    bit [15:0] sup_caps;
    bit [15:0] en_caps;
    bit [15:0] ttl_list [TTL_SLOTS];
    int        ttl_num;

    beat_t pending_beats[$];
    res_t  expected_results[$];
    beat_t cur_beat;
    res_t  exp_beat;

    bit        idle_en = 1;
    bit        send_hold = 0;
    bit        rx_hold_req = 0;
    int        rx_hold_left = 0;
    int        mismatches = 0;
    int        results_seen = 0;
    int        frames_done = 0;
    int        stall_cycles = 0;
    bit [8:0]  flags_seen = 0;
    bit [15:0] ttl_pool [12];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- decoder model ----------------
    task automatic reset_parse();
        phase = P_HDR0; cur_type = 0; cur_len = 0; remaining = 0; kept = 0;
        cur_sub = 0; aoid_len = 0; word = 0; mand_seen = 0; halted = 0;
    endtask

    task automatic clear_record();
        flags = 0; sup_caps = 0; en_caps = 0; ttl_num = 0;
        reset_parse();
    endtask

    task automatic go_short();
        flags |= F_SHORT;
        halted = 1;
    endtask

    task automatic mand_check();
        if (mand_seen != 4'hf)
            flags |= F_MAND;
    endtask

    task automatic go_skip(int n);
        remaining = n[8:0];
        kept = 0;
        phase = (remaining != 0) ? P_SKIP : P_HDR0;
    endtask

    task automatic go_field(int n, int limit);
        int k;
        k = (n < limit) ? n : limit;
        if (k != n)
            flags |= F_TRUNC;
        remaining = n[8:0];
        kept = k[8:0];
        phase = P_FIELD;
    endtask

    task automatic go_addr(int n);
        remaining = n[8:0];
        kept = n[8:0];
        phase = P_FIELD;
    endtask

    function automatic bit tick_down();
        if (remaining != 0)
            remaining--;
        return remaining == 0;
    endfunction

    task automatic keep_ttl(bit [15:0] v);
        if (ttl_dedup)
            for (int i = 0; i < ttl_num; i++)
                if (ttl_list[i] == v)
                    return;
        if (ttl_num < TTL_SLOTS)
        begin
            ttl_list[ttl_num] = v;
            ttl_num++;
        end
        else
            flags |= F_TTL;
    endtask

    task automatic start_id();
        int s;
        int l;
        int kind;
        s = cur_sub;
        l = cur_len;
        kind = 0;
        if (cur_type == 1)
        begin
            if (s == 1 || s == 2 || s == 4 || s == 6 || s == 7) kind = 1;
            else if (s == 3) kind = 2;
            else if (s == 5) kind = 4;
        end
        else
        begin
            if (s == 1 || s == 3 || s == 5 || s == 7) kind = 1;
            else if (s == 2) kind = 2;
            else if (s == 4) kind = 4;
            else if (s == 6) kind = 5;
        end
        case (kind)
            1: if (l < 2) go_short(); else go_field(l - 1, str_limit);
            2: if (l < 2) go_short(); else go_field(l - 1, str_limit >> 1);
            4: phase = P_FAM;
            5: if (l < 2) go_short(); else go_skip(l - 1);
            default:
            begin
                flags |= F_RSVD;
                if (l < 1) go_short(); else go_skip(l - 1);
            end
        endcase
    endtask

    task automatic start_tlv(bit [7:0] b);
        cur_type = word[7:1];
        cur_len = {word[0], b};
        cur_sub = 0;
        if (cur_type < 4)
            mand_seen[cur_type[1:0]] = 1'b1;
        else if (cur_type <= 8)
            flags |= F_OPT;
        if (cur_type == 0)
        begin
            mand_check();
            halted = 1;
        end
        else if (cur_type == 1 || cur_type == 2)
            phase = P_SUB;
        else if (cur_type == 3)
            phase = P_TTL0;
        else if (cur_type > 8 && cur_type < 127)
        begin
            flags |= F_RSVD;
            go_skip(cur_len);
        end
        else if (!opt_en)
            go_skip(cur_len);
        else if (cur_type <= 6)
        begin
            if (cur_len < 1) go_short(); else go_field(cur_len, str_limit);
        end
        else if (cur_type == 7)
        begin
            remaining = 4;
            phase = P_CAPS;
        end
        else if (cur_type == 8)
            phase = P_MLEN;
        else
        begin
            flags |= F_ORG;
            remaining = 3;
            phase = P_OUI;
        end
    endtask

    function automatic bit [3:0] tag_now();
        if (phase == P_HDR0 || phase == P_HDR1)
            return TAG_NONE;
        if (phase == P_SKIP && cur_type >= 4)
            return TAG_NONE;
        case (cur_type)
            7'd1: return TAG_CHASSIS;
            7'd2: return TAG_PORT;
            7'd3: return TAG_TTL;
            7'd4: return TAG_PDESC;
            7'd5: return TAG_SYSNAME;
            7'd6: return TAG_SYSDESC;
            7'd7: return TAG_CAPS;
            7'd8: return TAG_MGMT;
            default: return TAG_NONE;
        endcase
    endfunction

    task automatic take_byte(bit [7:0] b, output bit v);
        v = 0;
        case (phase)
            P_HDR0: begin word = b; phase = P_HDR1; end
            P_HDR1: start_tlv(b);
            P_SUB: begin cur_sub = b; start_id(); end
            P_FAM:
            begin
                cur_sub = b;
                if (b == 1) go_addr(4);
                else if (b == 2) go_addr(16);
                else if (cur_len < 3) go_short();
                else go_field(cur_len - 2, str_limit >> 1);
            end
            P_FIELD:
            begin
                v = kept != 0;
                if (v) kept--;
                if (tick_down()) phase = (cur_type == 8) ? P_MIFT : P_HDR0;
            end
            P_SKIP: if (tick_down()) phase = P_HDR0;
            P_TTL0: begin word = b; phase = P_TTL1; v = 1; end
            P_TTL1:
            begin
                keep_ttl({word[7:0], b});
                phase = P_HDR0;
                v = 1;
            end
            P_CAPS:
            begin
                word = {word[7:0], b};
                v = 1;
                if (tick_down())
                begin
                    en_caps |= word;
                    phase = P_HDR0;
                end
                else if (remaining == 2)
                    sup_caps |= word;
            end
            P_MLEN: begin aoid_len = b; phase = P_MFAM; end
            P_MFAM:
            begin
                cur_sub = b;
                if (b == 1) go_addr(4);
                else if (b == 2) go_addr(16);
                else if (aoid_len < 2) go_short();
                else go_field(aoid_len - 1, str_limit >> 1);
            end
            P_MIFT: begin remaining = 4; phase = P_MIFN; end
            P_MIFN: if (tick_down()) phase = P_MOIDL;
            P_MOIDL:
            begin
                aoid_len = b;
                if (b > 1)
                begin
                    remaining = b;
                    phase = P_MOID;
                end
                else
                    phase = P_HDR0;
            end
            P_MOID: if (tick_down()) phase = P_HDR0;
            P_OUI: if (tick_down()) phase = P_ORGSUB;
            P_ORGSUB:
            begin
                cur_sub = b;
                if (cur_len < 4) go_short(); else go_skip(cur_len - 4);
            end
            default: phase = P_HDR0;
        endcase
    endtask

    task automatic predict_parse(input beat_t it, output res_t r);
        bit v;
        r = '0;
        v = 0;
        if (it.clear)
            clear_record();
        else
        begin
            if (!halted && !(phase == P_HDR0 && it.last))
            begin
                r.field_tag = tag_now();
                take_byte(it.data, v);
            end
            if (r.field_tag != TAG_NONE)
                r.field_subtype = cur_sub;
            if (it.last)
            begin
                if (!halted)
                begin
                    if (phase == P_HDR0) mand_check();
                    else flags |= F_SNAP;
                end
                reset_parse();
                r.frame_done = 1;
            end
        end
        r.byte_valid = v;
        r.field_byte = v ? it.data : 8'd0;
        r.status_flags = flags;
        r.supported_caps = sup_caps;
        r.caps_enabled = en_caps;
        r.ttl_count = ttl_num[3:0];
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_parse(cur_beat, exp_beat);
                expected_results.push_back(exp_beat);
            end
            if (s_tvalid && !s_tready)
                ;
            else if (pending_beats.size() > 0 && !send_hold
                     && !(idle_en && $urandom_range(0, 99) < 18))
            begin
                cur_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= cur_beat.data;
                s_tuser <= cur_beat.clear;
                s_tlast <= cur_beat.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ---------------- receiver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 0;
                rx_hold_left = 400;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idle_en && $urandom_range(0, 99) < 18);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        res_t act;
        res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            act.field_tag = m_tuser[3:0];
            act.byte_valid = m_tuser[4];
            act.frame_done = m_tlast;
            act.field_subtype = m_tdata[7:0];
            act.field_byte = m_tdata[15:8];
            act.status_flags = m_tdata[24:16];
            act.supported_caps = m_tdata[40:25];
            act.caps_enabled = m_tdata[56:41];
            act.ttl_count = m_tdata[60:57];
            results_seen++;
            flags_seen |= act.status_flags;
            if (act.frame_done)
                frames_done++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %p", act);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (act !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d mismatch\n  exp %p\n  got %p",
                                 results_seen, exp_r, act);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 5000)
        begin
            $display("watchdog: no progress");
            $display("lldp_tlv_frame_parser regression: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_beat(bit clr, bit [7:0] d, bit lst);
        beat_t it;
        it.clear = clr;
        it.data = d;
        it.last = lst;
        pending_beats.push_back(it);
    endtask

    task automatic add_frame(bit [7:0] fr[$]);
        foreach (fr[i])
            add_beat(0, fr[i], i == fr.size() - 1);
    endtask

    task automatic add_rand(ref bit [7:0] q[$], input int n);
        repeat (n)
            q.push_back($urandom_range(0, 255));
    endtask

    function automatic int body_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(100, 420)
                                            : $urandom_range(0, 12);
    endfunction

    task automatic add_tlv(ref bit [7:0] fr[$], input int t);
        bit [7:0] body[$];
        bit [8:0] len;
        int fam;
        int n;
        case (t)
            1, 2:
            begin
                body.push_back($urandom_range(0, 8));
                if ((t == 1 && body[0] == 5) || (t == 2 && body[0] == 4))
                begin
                    fam = $urandom_range(0, 3);
                    body.push_back(fam);
                    add_rand(body, fam == 1 ? 4 : fam == 2 ? 16 : body_len());
                end
                else
                    add_rand(body, body_len());
            end
            3:
            begin
                n = ttl_pool[$urandom_range(0, 11)];
                body.push_back(n[15:8]);
                body.push_back(n[7:0]);
            end
            7: add_rand(body, 4);
            8:
            begin
                fam = $urandom_range(1, 3);
                n = fam == 1 ? 4 : fam == 2 ? 16 : $urandom_range(0, 8);
                body.push_back(n + 1);
                body.push_back(fam);
                add_rand(body, n + 5);
                n = $urandom_range(0, 6);
                body.push_back(n);
                add_rand(body, n);
            end
            127: add_rand(body, 4 + body_len());
            default: add_rand(body, body_len());
        endcase
        // occasional bad length
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                if (body.size() > 0)
                    void'(body.pop_back());
        len = body.size();
        fr.push_back({t[6:0], len[8]});
        fr.push_back(len[7:0]);
        fr = {fr, body};
    endtask

    task automatic add_random_frame();
        bit [7:0] fr[$];
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            add_beat(1, $urandom_range(0, 255), $urandom_range(0, 1));
            return;
        end
        if (pick < 12)
        begin
            add_rand(fr, $urandom_range(1, 30));
            add_frame(fr);
            return;
        end
        if ($urandom_range(0, 9) != 0) add_tlv(fr, 1);
        if ($urandom_range(0, 9) != 0) add_tlv(fr, 2);
        if ($urandom_range(0, 9) != 0) add_tlv(fr, 3);
        repeat ($urandom_range(0, 4))
        begin
            pick = $urandom_range(0, 9);
            add_tlv(fr, pick < 7 ? pick + 2 : pick == 7 ? 127 : pick == 8 ? 3
                        : $urandom_range(9, 126));
        end
        if ($urandom_range(0, 9) < 7)
        begin
            fr.push_back(8'h00);
            fr.push_back(8'h00);
            add_rand(fr, $urandom_range(0, 2));
        end
        // broken frame: cut short
        if (pick < 20 && fr.size() > 2)
            fr = fr[0:$urandom_range(0, fr.size() - 2)];
        add_frame(fr);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_MAX_STR: str_limit = val;
            REG_OPT_EN:  opt_en = val[0];
            REG_TTL_AGG: ttl_dedup = val[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int lim[6] = '{255, 2, 511, 3, 20, 9};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        str_limit = 255;
        opt_en = 1;
        ttl_dedup = 1;
        clear_record();
        foreach (ttl_pool[i])
            ttl_pool[i] = $urandom_range(0, 65535);
        ttl_pool[0] = 16'h0000;
        ttl_pool[1] = 16'hffff;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone last byte at header, End TLV, short ID, clear
        add_beat(0, 8'hff, 1);
        add_frame('{8'h00, 8'h00, 8'hab, 8'hcd});
        add_frame('{8'h02, 8'h01, 8'h04, 8'h55, 8'h66});
        add_frame('{8'h02, 8'h00, 8'h00, 8'h11});
        add_frame('{8'hfe, 8'h03, 8'h00, 8'h80});
        add_frame('{8'h06, 8'h02, 8'hff, 8'hff, 8'h00, 8'h00});
        add_beat(1, 8'h00, 0);
        add_beat(1, 8'hff, 1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_MAX_STR, lim[ph]);
            write_reg(REG_OPT_EN, (ph == 2 || ph == 5) ? 0 : 1);
            write_reg(REG_TTL_AGG, ph % 2 == 0);
            idle_en = (ph != 3);
            while (pending_beats.size() < 230)
                add_random_frame();
            if (ph == 1)
            begin
                repeat (20) @(posedge clk);
                rx_hold_req = 1;
            end
            if (ph == 4)
            begin
                // sender waits for every result before going on
                while (pending_beats.size() > 115)
                    @(posedge clk);
                send_hold = 1;
                while (expected_results.size() > 0 || s_tvalid)
                    @(posedge clk);
                send_hold = 0;
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d result beats over %0d frames, 6 register settings",
                 results_seen, frames_done);
        $display("status bits seen: %b, mismatches: %0d", flags_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("lldp_tlv_frame_parser regression: pass");
        else
            $display("lldp_tlv_frame_parser regression: fail");
        $finish;
    end

endmodule

FILE: files.f
src/lltp_pkg.sv
src/lltp_ctrl.sv
src/lltp_dp.sv
src/lldp_tlv_frame_parser.sv
src/lltp_checker.sv
test/tb.sv
